// ----- src/ttpg_pkg.sv -----
// ----------------------------------------------------------------------------
// ttpg_pkg
// shared types, timing constants and the control store of the tape player
// ----------------------------------------------------------------------------
package ttpg_pkg;

  localparam int unsigned IMAGE_BYTES = 65536;
  localparam int unsigned IMG_AW      = $clog2(IMAGE_BYTES);
  localparam int unsigned RA_W        = 19;

  localparam logic [16:0] POS_MAX    = 17'h1FFFF;
  localparam logic [12:0] PILOT_HDR  = 13'd4032;
  localparam logic [12:0] PILOT_DATA = 13'd1611;
  localparam logic [12:0] BYTE_BITS  = 13'd8;
  localparam logic [23:0] PILOT_T    = 24'd2168;
  localparam logic [23:0] SYNC1_T    = 24'd667;
  localparam logic [23:0] SYNC2_T    = 24'd735;
  localparam logic [23:0] PAUSE_T    = 24'd2168000;
  localparam logic [10:0] BIT1_T     = 11'd1710;
  localparam logic [10:0] BIT0_T     = 11'd855;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_START  = 3'd2,
    OP_STOP   = 3'd3,
    OP_REWIND = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    M_STOP     = 4'd0,
    M_PLAY     = 4'd1,
    M_PILOT    = 4'd2,
    M_PILOT_LO = 4'd3,
    M_PILOT_HI = 4'd4,
    M_SYNC_LO  = 4'd5,
    M_SYNC_HI  = 4'd6,
    M_BYTE     = 4'd7,
    M_BIT      = 4'd8,
    M_BIT_LO   = 4'd9,
    M_BIT_HI   = 4'd10,
    M_PAUSE    = 4'd11
  } mode_t;

  typedef enum logic [4:0] {
    U_NOP,
    U_SET_STOP,
    U_LVL_STOP,
    U_RD_BS0,
    U_RD_BS1,
    U_RD_BS2,
    U_PILOT_INIT,
    U_PILOT,
    U_PILOT_LO,
    U_PILOT_HI,
    U_SYNC_LO,
    U_SYNC_HI,
    U_OFS_INC,
    U_RD_DATA,
    U_LOAD_SHIFT,
    U_BIT_LOAD,
    U_BIT_LO,
    U_BIT_HI,
    U_BLK_END,
    U_PAUSE_END
  } uop_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_BS_GE_LEN,
    C_LT_PILOT,
    C_LT_SYNC1,
    C_LT_SYNC2,
    C_LT_BIT,
    C_LT_PAUSE,
    C_OFS_GT_LEN,
    C_PC_ZERO
  } cond_t;

  typedef enum logic [4:0] {
    W_RET0     = 5'd0,
    W_STOP_SET = 5'd1,
    W_STOP     = 5'd2,
    W_PLAY0    = 5'd3,
    W_PLAY1    = 5'd4,
    W_PLAY2    = 5'd5,
    W_PLAY3    = 5'd6,
    W_PILOT    = 5'd7,
    W_PILOT_LO = 5'd8,
    W_PILOT_HI = 5'd9,
    W_SYNC_LO  = 5'd10,
    W_SYNC_HI  = 5'd11,
    W_BYTE0    = 5'd12,
    W_BYTE1    = 5'd13,
    W_BYTE2    = 5'd14,
    W_BIT      = 5'd15,
    W_BIT_LO   = 5'd16,
    W_BIT_HI   = 5'd17,
    W_BLK_END  = 5'd18,
    W_PAUSE    = 5'd19
  } upc_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_RUN,
    SQ_REPORT
  } seq_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    upc_t  tgt;
    logic  fin;
    logic  hit;
  } cw_t;

  typedef struct packed {
    logic bs_ge_len;
    logic lt_pilot;
    logic lt_sync1;
    logic lt_sync2;
    logic lt_bit;
    logic lt_pause;
    logic ofs_gt_len;
    logic pc_zero;
  } flags_t;

  typedef struct packed {
    uop_t op;
    logic fin;
    logic hit;
    logic busy;
    logic report;
  } seq_out_t;

  function automatic cw_t mk_cw(uop_t op, cond_t cond, upc_t tgt, logic fin, logic hit);
    cw_t w;
    w.op   = op;
    w.cond = cond;
    w.tgt  = tgt;
    w.fin  = fin;
    w.hit  = hit;
    return w;
  endfunction

  // control store: a true condition jumps and skips the word's operation
  function automatic cw_t ctl_rom(upc_t a);
    cw_t w;
    case (a)
      W_RET0:     w = mk_cw(U_NOP,        C_NONE,       W_RET0,     1'b1, 1'b0);
      W_STOP_SET: w = mk_cw(U_SET_STOP,   C_NONE,       W_RET0,     1'b0, 1'b0);
      W_STOP:     w = mk_cw(U_LVL_STOP,   C_NONE,       W_RET0,     1'b1, 1'b1);
      W_PLAY0:    w = mk_cw(U_RD_BS0,     C_BS_GE_LEN,  W_STOP_SET, 1'b0, 1'b0);
      W_PLAY1:    w = mk_cw(U_RD_BS1,     C_NONE,       W_RET0,     1'b0, 1'b0);
      W_PLAY2:    w = mk_cw(U_RD_BS2,     C_NONE,       W_RET0,     1'b0, 1'b0);
      W_PLAY3:    w = mk_cw(U_PILOT_INIT, C_NONE,       W_RET0,     1'b0, 1'b0);
      W_PILOT:    w = mk_cw(U_PILOT,      C_NONE,       W_RET0,     1'b1, 1'b1);
      W_PILOT_LO: w = mk_cw(U_PILOT_LO,   C_LT_PILOT,   W_RET0,     1'b1, 1'b1);
      W_PILOT_HI: w = mk_cw(U_PILOT_HI,   C_LT_PILOT,   W_RET0,     1'b1, 1'b1);
      W_SYNC_LO:  w = mk_cw(U_SYNC_LO,    C_LT_SYNC1,   W_RET0,     1'b1, 1'b1);
      W_SYNC_HI:  w = mk_cw(U_SYNC_HI,    C_LT_SYNC2,   W_RET0,     1'b1, 1'b1);
      W_BYTE0:    w = mk_cw(U_OFS_INC,    C_NONE,       W_RET0,     1'b0, 1'b0);
      W_BYTE1:    w = mk_cw(U_RD_DATA,    C_OFS_GT_LEN, W_BLK_END,  1'b0, 1'b0);
      W_BYTE2:    w = mk_cw(U_LOAD_SHIFT, C_NONE,       W_RET0,     1'b0, 1'b0);
      W_BIT:      w = mk_cw(U_BIT_LOAD,   C_PC_ZERO,    W_BYTE0,    1'b0, 1'b0);
      W_BIT_LO:   w = mk_cw(U_BIT_LO,     C_LT_BIT,     W_RET0,     1'b1, 1'b1);
      W_BIT_HI:   w = mk_cw(U_BIT_HI,     C_LT_BIT,     W_RET0,     1'b1, 1'b1);
      W_BLK_END:  w = mk_cw(U_BLK_END,    C_NONE,       W_RET0,     1'b0, 1'b0);
      W_PAUSE:    w = mk_cw(U_PAUSE_END,  C_LT_PAUSE,   W_RET0,     1'b1, 1'b1);
      default:    w = mk_cw(U_NOP,        C_NONE,       W_RET0,     1'b1, 1'b0);
    endcase
    return w;
  endfunction

  function automatic upc_t entry_of(mode_t m);
    upc_t a;
    case (m)
      M_STOP:     a = W_STOP;
      M_PLAY:     a = W_PLAY0;
      M_PILOT:    a = W_PILOT;
      M_PILOT_LO: a = W_PILOT_LO;
      M_PILOT_HI: a = W_PILOT_HI;
      M_SYNC_LO:  a = W_SYNC_LO;
      M_SYNC_HI:  a = W_SYNC_HI;
      M_BYTE:     a = W_BYTE0;
      M_BIT:      a = W_BIT;
      M_BIT_LO:   a = W_BIT_LO;
      M_BIT_HI:   a = W_BIT_HI;
      M_PAUSE:    a = W_PAUSE;
      default:    a = W_RET0;
    endcase
    return a;
  endfunction

endpackage

// ----- src/tap_tape_pulse_generator.sv -----
// result path: the strobe is registered from the report state, which a non-tick word
//   enters straight after it is accepted and a tick word after its control store run
// throughput: the next word is taken in the cycle its predecessor's result shows
// the registered image read and the one-step-per-cycle sequencer set this timing
// reset: synchronous, active low; clears playback state and tape length, not the image
// ----------------------------------------------------------------------------
// tap_tape_pulse_generator
// plays a length-prefixed tape image as pilot, sync, data and pause pulses
// ----------------------------------------------------------------------------
module tap_tape_pulse_generator
  import ttpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [23:0] in_elapsed_ticks,
  input  logic [15:0] in_load_address,
  input  logic [7:0]  in_load_byte,
  output logic        out_strobe,
  output logic        out_edge_taken,
  output logic        out_tape_level,
  output logic        out_playing,
  output logic [16:0] out_tape_position,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic acc, go_tick, go_other;
  seq_out_t so;
  flags_t   flags;

  mode_t       mode_r, mode_nxt;
  logic [12:0] pc_r, pc_nxt, pc_dec;
  logic [16:0] bs_r, bs_nxt;
  logic [15:0] len_r, len_nxt;
  logic [17:0] ofs_r, ofs_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [10:0] blen_r, blen_nxt;
  logic        level_r, level_nxt;
  logic        edge_r, edge_nxt;
  logic [23:0] ticks_r;
  logic [16:0] tape_len_r;

  logic [7:0]      mem [IMAGE_BYTES];
  logic [7:0]      mem_q_r;
  logic            rd_ok_r;
  logic [RA_W-1:0] rd_addr;
  logic            rd_ok;
  logic [7:0]      rd_data;

  logic [17:0] blk_next;
  logic signed [19:0] pos_sum;
  logic [16:0] pos_sat;

  logic        out_strobe_r, out_edge_r, out_level_r, out_playing_r;
  logic [16:0] out_pos_r;

  assign acc      = start && !busy;
  assign go_tick  = acc && (in_opcode == OP_TICK);
  assign go_other = acc && (in_opcode != OP_TICK);
  assign busy     = so.busy;

  ttpg_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .go_tick  (go_tick),
    .go_other (go_other),
    .go_mode  (mode_r),
    .flags    (flags),
    .so       (so)
  );

  // condition flags
  always_comb begin
    flags.bs_ge_len  = bs_r >= tape_len_r;
    flags.lt_pilot   = ticks_r < PILOT_T;
    flags.lt_sync1   = ticks_r < SYNC1_T;
    flags.lt_sync2   = ticks_r < SYNC2_T;
    flags.lt_bit     = ticks_r < {13'd0, blen_r};
    flags.lt_pause   = ticks_r < PAUSE_T;
    flags.ofs_gt_len = !ofs_r[17] && (ofs_r[16:0] > {1'b0, len_r});
    flags.pc_zero    = pc_r == 13'd0;
  end

  // image read address and range check
  always_comb begin
    case (so.op)
      U_RD_BS1: rd_addr = RA_W'({2'b00, bs_r}) + RA_W'(1);
      U_RD_BS2: rd_addr = RA_W'({2'b00, bs_r}) + RA_W'(2);
      U_RD_DATA: begin
        if (ofs_r[17]) begin
          rd_addr = RA_W'({2'b00, bs_r}) + RA_W'(1);
        end else begin
          rd_addr = RA_W'({2'b00, bs_r}) + RA_W'(2) + RA_W'({2'b00, ofs_r[16:0]});
        end
      end
      default: rd_addr = RA_W'({2'b00, bs_r});
    endcase
    rd_ok = (rd_addr < RA_W'({2'b00, tape_len_r})) && (rd_addr < RA_W'(IMAGE_BYTES));
  end

  assign rd_data = rd_ok_r ? mem_q_r : 8'h00;

  always_ff @(posedge clk) begin
    if (acc && (in_opcode == OP_LOAD)) begin
      mem[in_load_address[IMG_AW-1:0]] <= in_load_byte;
    end
    mem_q_r <= mem[rd_addr[IMG_AW-1:0]];
    rd_ok_r <= rd_ok;
  end

  assign pc_dec   = (pc_r != 13'd0) ? pc_r - 13'd1 : pc_r;
  assign blk_next = {1'b0, bs_r} + {2'b00, len_r} + 18'd2;

  // datapath
  always_comb begin
    mode_nxt  = mode_r;
    pc_nxt    = pc_r;
    bs_nxt    = bs_r;
    len_nxt   = len_r;
    ofs_nxt   = ofs_r;
    shift_nxt = shift_r;
    blen_nxt  = blen_r;
    level_nxt = level_r;
    edge_nxt  = edge_r;
    if (acc) begin
      edge_nxt = 1'b0;
      case (op_t'(in_opcode))
        OP_START: begin
          if (tape_len_r != 17'd0) mode_nxt = M_PLAY;
        end
        OP_STOP: mode_nxt = M_STOP;
        OP_REWIND: begin
          if (mode_r != M_STOP) mode_nxt = M_PLAY;
          bs_nxt  = 17'd0;
          len_nxt = 16'd0;
          ofs_nxt = 18'd0;
        end
        default: mode_nxt = mode_r;
      endcase
    end
    if (so.fin) edge_nxt = so.hit;
    case (so.op)
      U_SET_STOP: mode_nxt = M_STOP;
      U_LVL_STOP: level_nxt = 1'b1;
      U_RD_BS1:   len_nxt[7:0] = rd_data;
      U_RD_BS2:   len_nxt[15:8] = rd_data;
      U_PILOT_INIT: begin
        ofs_nxt  = '1;
        mode_nxt = M_PILOT;
        pc_nxt   = (rd_data != 8'h00) ? PILOT_DATA : PILOT_HDR;
      end
      U_PILOT: begin
        level_nxt = 1'b0;
        mode_nxt  = M_PILOT_LO;
      end
      U_PILOT_LO: begin
        level_nxt = 1'b1;
        mode_nxt  = M_PILOT_HI;
      end
      U_PILOT_HI: begin
        level_nxt = 1'b0;
        pc_nxt    = pc_dec;
        mode_nxt  = (pc_dec == 13'd0) ? M_SYNC_LO : M_PILOT_LO;
      end
      U_SYNC_LO: begin
        level_nxt = 1'b1;
        mode_nxt  = M_SYNC_HI;
      end
      U_SYNC_HI: begin
        level_nxt = 1'b0;
        mode_nxt  = M_BYTE;
      end
      U_OFS_INC: ofs_nxt = ofs_r + 18'd1;
      U_LOAD_SHIFT: begin
        shift_nxt = rd_data;
        pc_nxt    = BYTE_BITS;
        mode_nxt  = M_BIT;
      end
      U_BIT_LOAD: begin
        pc_nxt    = pc_r - 13'd1;
        blen_nxt  = shift_r[7] ? BIT1_T : BIT0_T;
        shift_nxt = {shift_r[6:0], 1'b0};
        mode_nxt  = M_BIT_LO;
      end
      U_BIT_LO: begin
        level_nxt = 1'b1;
        mode_nxt  = M_BIT_HI;
      end
      U_BIT_HI: begin
        level_nxt = 1'b0;
        mode_nxt  = M_BIT;
      end
      U_BLK_END: begin
        bs_nxt   = (blk_next > {1'b0, POS_MAX}) ? POS_MAX : blk_next[16:0];
        mode_nxt = M_PAUSE;
      end
      U_PAUSE_END: mode_nxt = M_PLAY;
      default:     level_nxt = level_nxt;
    endcase
  end

  // position readout, clamped to 0..POS_MAX
  assign pos_sum = $signed({3'b000, bs_r}) + $signed({{2{ofs_r[17]}}, ofs_r});
  always_comb begin
    if (pos_sum < 0) begin
      pos_sat = 17'd0;
    end else if (pos_sum > $signed({3'b000, POS_MAX})) begin
      pos_sat = POS_MAX;
    end else begin
      pos_sat = pos_sum[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_STOP;
      pc_r         <= 13'd0;
      bs_r         <= 17'd0;
      len_r        <= 16'd0;
      ofs_r        <= 18'd0;
      shift_r      <= 8'd0;
      blen_r       <= 11'd0;
      level_r      <= 1'b1;
      edge_r       <= 1'b0;
      tape_len_r   <= 17'd0;
      out_strobe_r <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      pc_r         <= pc_nxt;
      bs_r         <= bs_nxt;
      len_r        <= len_nxt;
      ofs_r        <= ofs_nxt;
      shift_r      <= shift_nxt;
      blen_r       <= blen_nxt;
      level_r      <= level_nxt;
      edge_r       <= edge_nxt;
      out_strobe_r <= so.report;
      if (psel && penable && pwrite && !paddr[2]) begin
        tape_len_r <= pwdata[16:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go_tick) ticks_r <= in_elapsed_ticks;
    if (so.report) begin
      out_edge_r    <= edge_r;
      out_level_r   <= level_r;
      out_playing_r <= mode_r != M_STOP;
      out_pos_r     <= pos_sat;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_edge_taken    = out_edge_r;
  assign out_tape_level    = out_level_r;
  assign out_playing       = out_playing_r;
  assign out_tape_position = out_pos_r;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {15'd0, tape_len_r};

`ifndef SYNTHESIS
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a word in flight");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  a_stop_reports_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_opcode == OP_STOP)) |=> ##1 (out_strobe && !out_playing))
    else $error("stop word did not report a stopped tape");

  a_stopped_edge_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_edge_taken && !out_playing) |-> out_tape_level)
    else $error("stopped tape reported with low level");
`endif

endmodule

// ----- src/ttpg_seq.sv -----
// ----------------------------------------------------------------------------
// ttpg_seq
// micro sequencer: step counter over the control store, conditional jumps
// ----------------------------------------------------------------------------
module ttpg_seq
  import ttpg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     go_tick,
  input  logic     go_other,
  input  mode_t    go_mode,
  input  flags_t   flags,
  output seq_out_t so
);

  seq_t state_r, state_nxt;
  upc_t upc_r, upc_nxt;
  cw_t  cw;
  logic taken;

  assign cw = ctl_rom(upc_r);

  always_comb begin
    case (cw.cond)
      C_NONE:       taken = 1'b0;
      C_BS_GE_LEN:  taken = flags.bs_ge_len;
      C_LT_PILOT:   taken = flags.lt_pilot;
      C_LT_SYNC1:   taken = flags.lt_sync1;
      C_LT_SYNC2:   taken = flags.lt_sync2;
      C_LT_BIT:     taken = flags.lt_bit;
      C_LT_PAUSE:   taken = flags.lt_pause;
      C_OFS_GT_LEN: taken = flags.ofs_gt_len;
      C_PC_ZERO:    taken = flags.pc_zero;
      default:      taken = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    upc_nxt   = upc_r;
    case (state_r)
      SQ_IDLE: begin
        if (go_tick) begin
          state_nxt = SQ_RUN;
          upc_nxt   = entry_of(go_mode);
        end else if (go_other) begin
          state_nxt = SQ_REPORT;
        end
      end
      SQ_RUN: begin
        if (taken) begin
          upc_nxt = cw.tgt;
        end else if (cw.fin) begin
          state_nxt = SQ_REPORT;
        end else begin
          upc_nxt = upc_t'(upc_r + 5'd1);
        end
      end
      SQ_REPORT: state_nxt = SQ_IDLE;
      default:   state_nxt = SQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    so.op     = U_NOP;
    so.fin    = 1'b0;
    so.hit    = 1'b0;
    so.busy   = 1'b1;
    so.report = 1'b0;
    case (state_r)
      SQ_IDLE: so.busy = 1'b0;
      SQ_RUN: begin
        so.op  = taken ? U_NOP : cw.op;
        so.fin = !taken && cw.fin;
        so.hit = cw.hit;
      end
      SQ_REPORT: so.report = 1'b1;
      default:   so.busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      upc_r   <= W_RET0;
    end else begin
      state_r <= state_nxt;
      upc_r   <= upc_nxt;
    end
  end

endmodule

// ----- test/tb_tap_tape_pulse_generator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tap_tape_pulse_generator
// self-checking bench for the tape pulse generator: a bench-side copy of the
// playback machine predicts the status word of every accepted word, and a
// checker compares each strobed result with the oldest prediction
// ----------------------------------------------------------------------------
module tb_tap_tape_pulse_generator;
  import ttpg_pkg::*;

  localparam logic [2:0]  OP_UNUSED5      = 3'd5;
  localparam logic [2:0]  OP_UNUSED7      = 3'd7;
  localparam logic [2:0]  REG_TAPE_LENGTH = 3'd0;
  localparam int          FILL_BYTES      = 1024;
  localparam int          IMAGE_END       = 10;
  localparam int          CYCLE_LIMIT     = 2000000;
  // two blocks: data block with flag ff, then header block with flag 00
  localparam logic [79:0] TAPE_IMAGE      = 80'h04_00_FF_00_A5_80_02_00_00_FF;

  typedef struct packed {
    logic        taken;
    logic        lvl;
    logic        running;
    logic [16:0] pos;
  } tape_status_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_opcode;
  logic [23:0] in_elapsed_ticks;
  logic [15:0] in_load_address;
  logic [7:0]  in_load_byte;
  logic        out_strobe;
  logic        out_edge_taken;
  logic        out_tape_level;
  logic        out_playing;
  logic [16:0] out_tape_position;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // bench copy of the player
  logic [7:0]  image_copy [0:IMAGE_BYTES-1];
  logic [16:0] tape_len;
  mode_t       cur_mode;
  logic [12:0] pulses_left;
  logic [16:0] blk_start;
  logic [15:0] blk_len;
  logic [17:0] byte_ofs;
  logic [7:0]  shift_reg;
  logic [10:0] half_ticks;
  logic        lvl;

  tape_status_t status_q [$];
  tape_status_t want_status;
  int           err_count   = 0;
  int           idle_pct    = 0;
  int           cycle_count = 0;

  tap_tape_pulse_generator u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_elapsed_ticks  (in_elapsed_ticks),
    .in_load_address   (in_load_address),
    .in_load_byte      (in_load_byte),
    .out_strobe        (out_strobe),
    .out_edge_taken    (out_edge_taken),
    .out_tape_level    (out_tape_level),
    .out_playing       (out_playing),
    .out_tape_position (out_tape_position),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    if (err_count < 100) $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic [7:0] image_byte(int unsigned a);
    if (a >= tape_len || a >= IMAGE_BYTES) return 8'h00;
    return image_copy[a[15:0]];
  endfunction

  // walks the player until an edge is due or taken
  function automatic logic advance_edge(logic [23:0] ticks);
    int          o;
    int unsigned nxt;
    int unsigned rd_addr;
    repeat (64) begin
      case (cur_mode)
        M_STOP: begin
          lvl = 1'b1;
          return 1'b1;
        end
        M_PLAY: begin
          if (blk_start >= tape_len) begin
            cur_mode = M_STOP;
          end else begin
            blk_len = 16'(image_byte(int'(blk_start)) + 256 * image_byte(int'(blk_start) + 1));
            byte_ofs = '1;
            if (image_byte(int'(blk_start) + 2) != 8'h00) pulses_left = PILOT_DATA;
            else pulses_left = PILOT_HDR;
            cur_mode = M_PILOT;
          end
        end
        M_PILOT: begin
          lvl = 1'b0;
          cur_mode = M_PILOT_LO;
          return 1'b1;
        end
        M_PILOT_LO: begin
          if (ticks < PILOT_T) return 1'b0;
          lvl = 1'b1;
          cur_mode = M_PILOT_HI;
          return 1'b1;
        end
        M_PILOT_HI: begin
          if (ticks < PILOT_T) return 1'b0;
          lvl = 1'b0;
          if (pulses_left != 0) pulses_left = pulses_left - 1'b1;
          if (pulses_left == 0) cur_mode = M_SYNC_LO;
          else cur_mode = M_PILOT_LO;
          return 1'b1;
        end
        M_SYNC_LO: begin
          if (ticks < SYNC1_T) return 1'b0;
          lvl = 1'b1;
          cur_mode = M_SYNC_HI;
          return 1'b1;
        end
        M_SYNC_HI: begin
          if (ticks < SYNC2_T) return 1'b0;
          lvl = 1'b0;
          cur_mode = M_BYTE;
          return 1'b1;
        end
        M_BYTE: begin
          byte_ofs = byte_ofs + 1'b1;
          o = int'($signed(byte_ofs));
          if (o > int'(blk_len)) begin
            nxt = int'(blk_start) + int'(blk_len) + 2;
            blk_start = (nxt > POS_MAX) ? POS_MAX : 17'(nxt);
            cur_mode = M_PAUSE;
          end else begin
            rd_addr = (o < 0) ? int'(blk_start) + 1 : int'(blk_start) + 2 + o;
            shift_reg = image_byte(rd_addr);
            pulses_left = BYTE_BITS;
            cur_mode = M_BIT;
          end
        end
        M_BIT: begin
          if (pulses_left == 0) begin
            cur_mode = M_BYTE;
          end else begin
            pulses_left = pulses_left - 1'b1;
            half_ticks = shift_reg[7] ? BIT1_T : BIT0_T;
            shift_reg = shift_reg << 1;
            cur_mode = M_BIT_LO;
          end
        end
        M_BIT_LO: begin
          if (ticks < {13'd0, half_ticks}) return 1'b0;
          lvl = 1'b1;
          cur_mode = M_BIT_HI;
          return 1'b1;
        end
        M_BIT_HI: begin
          if (ticks < {13'd0, half_ticks}) return 1'b0;
          lvl = 1'b0;
          cur_mode = M_BIT;
          return 1'b1;
        end
        M_PAUSE: begin
          if (ticks < PAUSE_T) return 1'b0;
          cur_mode = M_PLAY;
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    end
    return 1'b0;
  endfunction

  function automatic tape_status_t tape_step(logic [2:0] op, logic [23:0] ticks,
                                             logic [15:0] addr, logic [7:0] data);
    tape_status_t s;
    int           p;
    s.taken = 1'b0;
    case (op)
      OP_TICK:   s.taken = advance_edge(ticks);
      OP_LOAD:   image_copy[addr] = data;
      OP_START:  if (tape_len != 0) cur_mode = M_PLAY;
      OP_STOP:   cur_mode = M_STOP;
      OP_REWIND: begin
        if (cur_mode != M_STOP) cur_mode = M_PLAY;
        blk_start = '0;
        blk_len = '0;
        byte_ofs = '0;
      end
      default: ;
    endcase
    p = int'(blk_start) + int'($signed(byte_ofs));
    if (p < 0) p = 0;
    if (p > int'(POS_MAX)) p = int'(POS_MAX);
    s.lvl = lvl;
    s.running = (cur_mode != M_STOP);
    s.pos = p[16:0];
    return s;
  endfunction

  function automatic logic [23:0] pick_ticks();
    int unsigned r;
    logic [23:0] bound;
    r = $urandom_range(99);
    if (r < 70) return 24'($urandom_range(PAUSE_T, 24'hFFFFFF));
    if (r < 80) return 24'($urandom());
    if (r < 90) return 24'($urandom_range(0, 2500));
    case ($urandom_range(5))
      0:       bound = PILOT_T;
      1:       bound = SYNC1_T;
      2:       bound = SYNC2_T;
      3:       bound = {13'd0, BIT0_T};
      4:       bound = {13'd0, BIT1_T};
      default: bound = PAUSE_T;
    endcase
    return bound - 24'($urandom_range(1));
  endfunction

  task automatic send_word(logic [2:0] op, logic [23:0] ticks, logic [15:0] addr,
                           logic [7:0] data);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start            <= 1'b1;
    in_opcode        <= op;
    in_elapsed_ticks <= ticks;
    in_load_address  <= addr;
    in_load_byte     <= data;
    @(posedge clk);
    while (busy) @(posedge clk);
    status_q.push_back(tape_step(op, ticks, addr, data));
  endtask

  task automatic send_tick(logic [23:0] ticks);
    send_word(OP_TICK, ticks, 16'($urandom()), 8'($urandom()));
  endtask

  task automatic send_ctrl(logic [2:0] op);
    send_word(op, 24'($urandom()), 16'($urandom()), 8'($urandom()));
  endtask

  task automatic send_load(logic [15:0] addr, logic [7:0] data);
    send_word(OP_LOAD, 24'($urandom()), addr, data);
  endtask

  task automatic drain_results;
    start <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_tape_length(logic [16:0] value);
    drain_results();
    repeat (12) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= REG_TAPE_LENGTH;
    pwdata  <= {15'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tape_len = value;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {15'd0, value})
      report_mismatch($sformatf("tape_length read %h, want %h", prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (status_q.size() == 0) begin
        report_mismatch("result with no word pending");
      end else begin
        want_status = status_q.pop_front();
        if (out_edge_taken !== want_status.taken)
          report_mismatch($sformatf("edge_taken %b, want %b", out_edge_taken,
                                    want_status.taken));
        if (out_tape_level !== want_status.lvl)
          report_mismatch($sformatf("tape_level %b, want %b", out_tape_level,
                                    want_status.lvl));
        if (out_playing !== want_status.running)
          report_mismatch($sformatf("playing %b, want %b", out_playing,
                                    want_status.running));
        if (out_tape_position !== want_status.pos)
          report_mismatch($sformatf("tape_position %0d, want %0d", out_tape_position,
                                    want_status.pos));
      end
    end
  end

  // status words while stopped with no tape length
  task automatic test_idle_status;
    idle_pct = 0;
    write_tape_length(17'd0);
    send_tick(24'd0);
    send_tick(24'hFFFFFF);
    send_ctrl(OP_START);
    send_ctrl(OP_REWIND);
    send_ctrl(OP_STOP);
    for (int op = OP_UNUSED5; op <= OP_UNUSED7; op++) send_ctrl(3'(op));
    send_load(16'hFFFF, 8'hFF);
    send_load(16'h0000, 8'h00);
    send_tick(24'd1);
  endtask

  task automatic test_image_fill;
    idle_pct = 0;
    for (int a = 0; a < FILL_BYTES; a++) send_load(16'(a), 8'($urandom()));
    for (int a = 0; a < IMAGE_END; a++) send_load(16'(a), TAPE_IMAGE[79 - 8 * a -: 8]);
  endtask

  task automatic play_to_end;
    int guard;
    guard = 0;
    send_ctrl(OP_REWIND);
    send_ctrl(OP_START);
    while (cur_mode != M_STOP && guard < 40000) begin
      send_tick(pick_ticks());
      guard++;
    end
    send_tick(pick_ticks());
  endtask

  // both blocks through pilot, sync, data and pause, then end of image
  task automatic test_full_playback;
    idle_pct = 0;
    write_tape_length(17'(IMAGE_END));
    play_to_end();
  endtask

  // first block runs past the tape length, its tail reads as zero
  task automatic test_truncated_image;
    idle_pct = 38;
    write_tape_length(17'd5);
    play_to_end();
  endtask

  task automatic test_length_extremes;
    idle_pct = 0;
    write_tape_length(17'd1);
    send_ctrl(OP_REWIND);
    send_ctrl(OP_START);
    repeat (6) send_tick(pick_ticks());
    send_ctrl(OP_STOP);
    write_tape_length(17'h10000);
    send_ctrl(OP_REWIND);
    send_ctrl(OP_START);
    repeat (8) send_tick(pick_ticks());
    send_ctrl(OP_REWIND);
    repeat (4) send_tick(pick_ticks());
    send_ctrl(OP_STOP);
    send_tick(pick_ticks());
    write_tape_length(17'd0);
    send_ctrl(OP_START);
    send_tick(pick_ticks());
  endtask

  task automatic test_random_traffic;
    int          sent;
    int          burst;
    int unsigned k;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       write_tape_length(17'(IMAGE_END));
        1:       write_tape_length(17'($urandom_range(1, FILL_BYTES)));
        2:       write_tape_length(17'(FILL_BYTES));
        default: write_tape_length(17'(IMAGE_END));
      endcase
      case (ph)
        0:       idle_pct = 0;
        1:       idle_pct = 71;
        2:       idle_pct = 0;
        default: idle_pct = 38;
      endcase
      sent = 0;
      while (sent < 150) begin
        if ($urandom_range(99) < 30) begin
          send_ctrl(OP_REWIND);
          sent++;
        end
        send_ctrl(OP_START);
        burst = $urandom_range(5, 40);
        sent += burst + 1;
        repeat (burst) begin
          k = $urandom_range(99);
          if (k < 88) send_tick(pick_ticks());
          else if (k < 91)
            send_load(($urandom_range(99) < 70) ? 16'($urandom_range(FILL_BYTES - 1))
                                                 : 16'($urandom()), 8'($urandom()));
          else if (k < 94) send_ctrl(OP_STOP);
          else if (k < 96) send_ctrl(OP_START);
          else if (k < 98) send_ctrl(OP_REWIND);
          else send_ctrl(3'($urandom_range(OP_UNUSED5, OP_UNUSED7)));
        end
      end
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_opcode        <= OP_TICK;
    in_elapsed_ticks <= '0;
    in_load_address  <= '0;
    in_load_byte     <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= REG_TAPE_LENGTH;
    pwdata           <= '0;
    tape_len    = '0;
    cur_mode    = M_STOP;
    pulses_left = '0;
    blk_start   = '0;
    blk_len     = '0;
    byte_ofs    = '0;
    shift_reg   = '0;
    half_ticks  = '0;
    lvl         = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_status();
    test_image_fill();
    test_full_playback();
    test_truncated_image();
    test_length_extremes();
    test_random_traffic();

    drain_results();
    repeat (20) @(posedge clk);
    if (status_q.size() != 0) report_mismatch("expected results never arrived");
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ttpg_pkg.sv
src/ttpg_seq.sv
src/tap_tape_pulse_generator.sv
test/tb_tap_tape_pulse_generator.sv
